### design/lbvs_pkg.sv
// Package: shared widths, field offsets and fixed-point helpers for the skinning block.
`default_nettype none
package lbvs_pkg;

    localparam int DEFAULT_MAX_JOINTS = 64;
    localparam int INFLUENCES         = 4;
    localparam int ROW_WORDS          = 12;   // 3x4 row-major, elements 12..15 unused
    localparam int JIDX_W             = 6;
    localparam int WGT_W              = 16;

    // input transaction tdata layout, lowest bit first
    localparam int S_TDATA_W   = 328;
    localparam int OFS_ADDR    = 0;
    localparam int OFS_VALUE   = 10;
    localparam int OFS_POS     = 42;
    localparam int OFS_NRM     = 138;
    localparam int OFS_JOINTS  = 234;
    localparam int OFS_WEIGHTS = 258;

    localparam int M_TDATA_W   = 192;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SKIN = 1'b1;

    // saturate a 51-bit signed value to signed 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [50:0] v);
        logic hi_same;
        hi_same = (v[50:47] == 4'b0000) || (v[50:47] == 4'b1111);
        if (hi_same) begin
            sat48 = v[47:0];
        end else if (v[50]) begin
            sat48 = {1'b1, 47'b0};
        end else begin
            sat48 = {1'b0, {47{1'b1}}};
        end
    endfunction

    // saturate a 52-bit signed value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic hi_same;
        hi_same = (v[51:31] == 21'h0) || (v[51:31] == 21'h1FFFFF);
        if (hi_same) begin
            sat32 = v[31:0];
        end else if (v[51]) begin
            sat32 = {1'b1, 31'b0};
        end else begin
            sat32 = {1'b0, {31{1'b1}}};
        end
    endfunction

endpackage
`default_nettype wire

### design/linear_blend_vertex_skinning.sv
// Top level: four-influence linear blend skinning with a matrix palette memory.
`default_nettype none
// Linear blend skinning engine. A transaction with s_tuser = 0 writes one
// Q16.16 word of a joint's 3x4 matrix into the palette memory (address =
// joint*16 + element) and produces no result. A transaction with
// s_tuser = 1 skins a vertex: the four selected joint matrices transform
// the position (w=1) and normal (w=0), the per-joint results are blended
// with unsigned Q1.15 weights, and one result transaction carries the
// saturated Q16.16 position and normal. A vertex occupies the front end
// while one palette row (a whole joint matrix) is read per influence; the
// next transaction can be taken in the last of these issue cycles. A 4-entry
// result queue decouples m_tready; when four vertices are pending, s_tready
// drops. Palette words must be written before a vertex reads them; joints
// at or above MAX_JOINTS contribute zero.
module linear_blend_vertex_skinning
    import lbvs_pkg::*;
#(
    parameter int MAX_JOINTS = DEFAULT_MAX_JOINTS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // load_addr, load_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
    // joints_packed, weights_packed, zero pad
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,   // cmd
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x, skin_nrm_y, skin_nrm_z
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int JW       = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int QDEPTH   = 4;
    localparam int QW       = 2;

    // palette memory: one row per joint, twelve words per row
    logic [31:0] pal_mem [MAX_JOINTS][ROW_WORDS];
    logic [31:0] row_reg [ROW_WORDS];

    // vertex front end
    logic                   busy_reg;
    logic [1:0]             cnt_reg;
    logic signed [31:0]     vec_reg  [6];     // pos x,y,z then nrm x,y,z
    logic [4*JIDX_W-1:0]    joints_reg;
    logic [4*WGT_W-1:0]     weights_reg;

    logic       s_acc, load_acc, skin_acc, issue_free, room;
    logic [2:0] pend_reg;

    // stage 1: row read
    logic                   s1_vld_reg, s1_use_reg, s1_first_reg, s1_last_reg;
    logic [WGT_W-1:0]       s1_w_reg;
    logic signed [31:0]     s1_vec_reg [6];

    // stage 2: products
    logic                   s2_vld_reg, s2_use_reg, s2_first_reg, s2_last_reg;
    logic [WGT_W-1:0]       s2_w_reg;
    logic signed [63:0]     s2_prod_reg [18];
    logic signed [31:0]     s2_t_reg [3];

    // stage 3: per-joint values
    logic                   s3_vld_reg, s3_use_reg, s3_first_reg, s3_last_reg;
    logic [WGT_W-1:0]       s3_w_reg;
    logic signed [47:0]     s3_val_reg [6];
    logic signed [47:0]     s3_val_next [6];

    // stage 4: weighted values
    logic                   s4_vld_reg, s4_first_reg, s4_last_reg;
    logic signed [64:0]     s4_wp_reg [6];

    // accumulate
    logic                   done_reg;
    logic signed [66:0]     acc_reg [6];
    logic [M_TDATA_W-1:0]   res_next;

    // result queue
    logic [M_TDATA_W-1:0]   q_mem [QDEPTH];
    logic [QW-1:0]          q_wr_reg, q_rd_reg;
    logic [QW:0]            q_cnt_reg;
    logic                   m_acc;

    logic [5:0]             cur_joint;
    logic [8:0]             cur_j9;
    logic [JW-1:0]          rd_idx;
    logic [5:0]             ld_joint;
    logic [8:0]             ld_j9;
    logic [3:0]             ld_elem;

    // front end handshake: free when idle or in the last issue cycle
    assign issue_free = !busy_reg || (cnt_reg == 2'd3);
    assign room       = (pend_reg < 3'(QDEPTH));
    assign s_tready   = issue_free && room;
    assign s_acc      = s_tvalid && s_tready;
    assign load_acc   = s_acc && (s_tuser == CMD_LOAD);
    assign skin_acc   = s_acc && (s_tuser == CMD_SKIN);
    assign m_acc      = m_tvalid && m_tready;

    assign cur_joint = joints_reg[cnt_reg*JIDX_W +: JIDX_W];
    assign cur_j9    = {3'b0, cur_joint};
    assign rd_idx    = cur_j9[JW-1:0];

    assign ld_joint = s_tdata[OFS_ADDR+4 +: 6];
    assign ld_j9    = {3'b0, ld_joint};
    assign ld_elem  = s_tdata[OFS_ADDR +: 4];

    // palette write and whole-row read
    always_ff @(posedge aclk) begin
        if (load_acc && (ld_elem < 4'(ROW_WORDS)) && (ld_j9 < 9'(MAX_JOINTS))) begin
            pal_mem[ld_j9[JW-1:0]][ld_elem] <= s_tdata[OFS_VALUE +: 32];
        end
        row_reg <= pal_mem[rd_idx];
    end

    // issue sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            if (skin_acc) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 2'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skin_acc) begin
            for (int i = 0; i < 3; i++) begin
                vec_reg[i]     <= s_tdata[OFS_POS + 32*i +: 32];
                vec_reg[3 + i] <= s_tdata[OFS_NRM + 32*i +: 32];
            end
            joints_reg  <= s_tdata[OFS_JOINTS +: 4*JIDX_W];
            weights_reg <= s_tdata[OFS_WEIGHTS +: 4*WGT_W];
        end
    end

    // count vertices accepted but not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 3'd0;
        end else begin
            pend_reg <= pend_reg + {2'b0, skin_acc} - {2'b0, m_acc};
        end
    end

    // stage valid bits: stage 1 follows the row read, later stages and done follow in turn
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            s1_vld_reg <= busy_reg;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            done_reg   <= s4_vld_reg && s4_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_use_reg   <= (cur_j9 < 9'(MAX_JOINTS));
        s1_first_reg <= (cnt_reg == 2'd0);
        s1_last_reg  <= (cnt_reg == 2'd3);
        s1_w_reg     <= weights_reg[cnt_reg*WGT_W +: WGT_W];
        s1_vec_reg   <= vec_reg;
    end

    // stage 2: nine position and nine normal products
    always_ff @(posedge aclk) begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                s2_prod_reg[3*r + c]     <= $signed(row_reg[4*r + c]) * s1_vec_reg[c];
                s2_prod_reg[9 + 3*r + c] <= $signed(row_reg[4*r + c]) * s1_vec_reg[3 + c];
            end
            s2_t_reg[r] <= row_reg[4*r + 3];
        end
        s2_use_reg   <= s1_use_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_w_reg     <= s1_w_reg;
    end

    // stage 3: round each row to Q16.16, add translation for position, saturate
    always_comb begin
        logic signed [65:0] sp, sn;
        logic signed [50:0] vp, vn;
        for (int r = 0; r < 3; r++) begin
            sp = 66'(s2_prod_reg[3*r]) + 66'(s2_prod_reg[3*r + 1])
               + 66'(s2_prod_reg[3*r + 2]) + 66'sh8000;
            sn = 66'(s2_prod_reg[9 + 3*r]) + 66'(s2_prod_reg[9 + 3*r + 1])
               + 66'(s2_prod_reg[9 + 3*r + 2]) + 66'sh8000;
            vp = 51'(sp >>> 16) + 51'(s2_t_reg[r]);
            vn = 51'(sn >>> 16);
            s3_val_next[r]     = sat48(vp);
            s3_val_next[3 + r] = sat48(vn);
        end
    end

    always_ff @(posedge aclk) begin
        s3_val_reg   <= s3_val_next;
        s3_use_reg   <= s2_use_reg;
        s3_first_reg <= s2_first_reg;
        s3_last_reg  <= s2_last_reg;
        s3_w_reg     <= s2_w_reg;
    end

    // stage 4: apply weight, drop out-of-range joints
    always_ff @(posedge aclk) begin
        for (int i = 0; i < 6; i++) begin
            if (s3_use_reg) begin
                s4_wp_reg[i] <= 65'(s3_val_reg[i] * $signed({1'b0, s3_w_reg}));
            end else begin
                s4_wp_reg[i] <= '0;
            end
        end
        s4_first_reg <= s3_first_reg;
        s4_last_reg  <= s3_last_reg;
    end

    // blend accumulator, restart on the first influence
    always_ff @(posedge aclk) begin
        if (s4_vld_reg) begin
            for (int i = 0; i < 6; i++) begin
                acc_reg[i] <= (s4_first_reg ? 67'sd0 : acc_reg[i]) + 67'(s4_wp_reg[i]);
            end
        end
    end

    // round from Q.31 blend scale back to Q16.16 and saturate
    always_comb begin
        logic signed [66:0] rs;
        for (int i = 0; i < 6; i++) begin
            rs = acc_reg[i] + 67'sh4000;
            res_next[32*i +: 32] = sat32(52'(rs >>> 15));
        end
    end

    // result queue
    always_ff @(posedge aclk) begin
        if (done_reg) begin
            q_mem[q_wr_reg] <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg  <= '0;
            q_rd_reg  <= '0;
            q_cnt_reg <= '0;
        end else begin
            if (done_reg) begin
                q_wr_reg <= q_wr_reg + 1'b1;
            end
            if (m_acc) begin
                q_rd_reg <= q_rd_reg + 1'b1;
            end
            q_cnt_reg <= q_cnt_reg + {{QW{1'b0}}, done_reg} - {{QW{1'b0}}, m_acc};
        end
    end

    assign m_tvalid = (q_cnt_reg != '0);
    assign m_tdata  = q_mem[q_rd_reg];

endmodule
`default_nettype wire

### tb/sv/lbvs_skin_checker.sv
// Checker: watches both channels, predicts the skinned vertex and compares results.
module lbvs_skin_checker
    import lbvs_pkg::*;
#(
    parameter int MAX_JOINTS = DEFAULT_MAX_JOINTS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    output int                        fail_count,
    output int                        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MID_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint MID_MIN = -MID_MAX - 1;

    logic [31:0] palette_copy [1024];
    logic [M_TDATA_W-1:0] skinned_q [$];

    initial begin
        fail_count = 0;
        for (int i = 0; i < 1024; i++) palette_copy[i] = '0;
    end

    assign pending = skinned_q.size();

    task automatic mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic longint pal_word(input int idx);
        return longint'($signed(palette_copy[idx]));
    endfunction

    // one matrix row applied to v, rounded to Q16.16, clamped to 48 bits
    function automatic longint joint_row(input int base, input int r, input longint v0,
                                         input longint v1, input longint v2, input bit add_t);
        longint hi;
        longint lo;
        longint p;
        longint v [3];
        v[0] = v0; v[1] = v1; v[2] = v2;
        hi = 0;
        lo = 0;
        for (int c = 0; c < 3; c++) begin
            p = pal_word(base + r * 4 + c) * v[c];
            hi += p >>> 16;
            lo += p & 64'hFFFF;
        end
        hi += (lo + 64'sd32768) >>> 16;
        if (add_t) hi += pal_word(base + r * 4 + 3);
        if (hi > MID_MAX) hi = MID_MAX;
        if (hi < MID_MIN) hi = MID_MIN;
        return hi;
    endfunction

    function automatic logic [M_TDATA_W-1:0] skin_vertex(input logic [S_TDATA_W-1:0] d);
        longint pos [3];
        longint nrm [3];
        longint acc_hi [6];
        longint acc_lo [6];
        longint p;
        longint n;
        longint w;
        longint v;
        int j;
        logic [M_TDATA_W-1:0] res;
        for (int i = 0; i < 3; i++) begin
            pos[i] = longint'($signed(d[OFS_POS + 32 * i +: 32]));
            nrm[i] = longint'($signed(d[OFS_NRM + 32 * i +: 32]));
        end
        for (int i = 0; i < 6; i++) begin
            acc_hi[i] = 0;
            acc_lo[i] = 0;
        end
        for (int k = 0; k < INFLUENCES; k++) begin
            j = int'(d[OFS_JOINTS + JIDX_W * k +: JIDX_W]);
            w = longint'(d[OFS_WEIGHTS + WGT_W * k +: WGT_W]);
            if (j < MAX_JOINTS) begin
                for (int r = 0; r < 3; r++) begin
                    p = joint_row(j * 16, r, pos[0], pos[1], pos[2], 1'b1) * w;
                    n = joint_row(j * 16, r, nrm[0], nrm[1], nrm[2], 1'b0) * w;
                    acc_hi[r] += p >>> 15;
                    acc_lo[r] += p & 64'h7FFF;
                    acc_hi[3 + r] += n >>> 15;
                    acc_lo[3 + r] += n & 64'h7FFF;
                end
            end
        end
        for (int i = 0; i < 6; i++) begin
            v = acc_hi[i] + ((acc_lo[i] + 64'sd16384) >>> 15);
            if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
            if (v < -64'sh8000_0000) v = -64'sh8000_0000;
            res[32 * i +: 32] = v[31:0];
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        logic [M_TDATA_W-1:0] want;
        if (aresetn) begin
            // input side: update the palette copy or queue a prediction
            if (s_tvalid && s_tready) begin
                if (s_tuser == CMD_LOAD) begin
                    palette_copy[s_tdata[OFS_ADDR +: 10]] = s_tdata[OFS_VALUE +: 32];
                end else begin
                    skinned_q.push_back(skin_vertex(s_tdata));
                end
            end
            // result side: compare against the oldest prediction
            if (m_tvalid && m_tready) begin
                if (skinned_q.size() == 0) begin
                    mismatch("result with no vertex outstanding");
                end else begin
                    want = skinned_q.pop_front();
                    for (int i = 0; i < 6; i++) begin
                        if (m_tdata[32 * i +: 32] !== want[32 * i +: 32])
                            mismatch($sformatf("field %0d got %h want %h", i,
                                               m_tdata[32 * i +: 32], want[32 * i +: 32]));
                    end
                end
            end
        end
    end
endmodule

### tb/sv/tb_linear_blend_vertex_skinning.sv
// Testbench top: drives palette loads and vertices, shapes both handshakes, gives the verdict.
module tb_linear_blend_vertex_skinning;
    timeunit 1ns;
    timeprecision 1ps;
    import lbvs_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 500;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // load_addr, load_value, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
    // joints_packed, weights_packed, zero pad
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;   // cmd
    logic                 m_tvalid;
    logic                 m_tready;
    // skin_pos_x, skin_pos_y, skin_pos_z, skin_nrm_x, skin_nrm_y, skin_nrm_z
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   cycles;
    int                   results_taken;
    bit                   long_stall_done;

    linear_blend_vertex_skinning dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    lbvs_skin_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // hard stop on a hung pipeline
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("tb_linear_blend_vertex_skinning NOT OK");
                $finish;
            end
        end
    end

    // Draw a Q16.16 word: extremes, small magnitudes, or anything at all.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 3) == 0 ? 32'h0 : 32'hFFFF_FFFF;
            3, 4: return 32'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
            default: return $urandom;
        endcase
    endfunction

    // Hold each transaction until accepted; idle a random gap before it.
    task automatic send(input logic cmd, input logic [9:0] addr, input logic [31:0] value,
                        input logic [95:0] pos, input logic [95:0] nrm,
                        input logic [23:0] joints, input logic [63:0] weights);
        int gap;
        gap = $urandom_range(0, 14);
        if ($urandom_range(0, 3) == 0) gap = 0;   // stretches of back-to-back traffic
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, weights, joints, nrm, pos, value, addr};
        @(posedge aclk iff s_tready);
    endtask

    task automatic load_word(input logic [9:0] addr, input logic [31:0] value);
        send(CMD_LOAD, addr, value, {$urandom, $urandom, $urandom},
             {$urandom, $urandom, $urandom}, 24'($urandom), {$urandom, $urandom});
    endtask

    task automatic skin(input logic [95:0] pos, input logic [95:0] nrm,
                        input logic [23:0] joints, input logic [63:0] weights);
        send(CMD_SKIN, 10'($urandom), $urandom, pos, nrm, joints, weights);
    endtask

    // Fill one joint with a near-rigid transform, sometimes with wild entries.
    task automatic fill_joint(input int j, input bit wild);
        logic [31:0] v;
        for (int e = 0; e < 12; e++) begin
            if (wild) v = pick_word();
            else if (e % 4 == 3) v = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
            else if (e % 5 == 0) v = 32'h0001_0000 + 32'($urandom_range(0, 32'h3FFF)) - 32'h2000;
            else v = 32'($signed($urandom_range(0, 32'h3FFF)) - 32'sh2000);
            load_word(10'(j * 16 + e), v);
        end
    endtask

    function automatic logic [95:0] pick_vec();
        return {pick_word(), pick_word(), pick_word()};
    endfunction

    // Weights: a convex set most of the time, otherwise arbitrary.
    function automatic logic [63:0] pick_weights();
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        if ($urandom_range(0, 2) == 0) return {$urandom, $urandom};
        a = 16'($urandom_range(0, 32768));
        b = 16'($urandom_range(0, 32768 - a));
        c = 16'($urandom_range(0, 32768 - a - b));
        return {16'(32768 - a - b - c), c, b, a};
    endfunction

    // Result side: random stall per transaction, one long hold-off mid-run.
    initial begin
        int gap;
        m_tready <= 1'b0;
        results_taken = 0;
        long_stall_done = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!long_stall_done && results_taken >= 200) begin
                long_stall_done = 1;
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
            end
            gap = $urandom_range(0, 14);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk iff m_tvalid);
            results_taken++;
        end
    end

    initial begin
        s_tvalid <= 1'b0;
        s_tuser  <= CMD_LOAD;
        s_tdata  <= '0;
        aresetn  <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn  <= 1'b1;
        @(posedge aclk);

        // Initialize every joint before any vertex reads the palette.
        for (int j = 0; j < DEFAULT_MAX_JOINTS; j++) fill_joint(j, j == 62);

        // Directed: extremes of position, normal, joints and weights.
        skin('0, '0, '0, {48'b0, 16'h8000});
        skin({3{32'h0001_0000}}, {3{32'h0001_0000}}, {4{6'd63}}, {4{16'h2000}});
        skin({3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, {4{6'd62}}, {4{16'hFFFF}});
        skin({3{32'h8000_0000}}, {3{32'h8000_0000}}, {4{6'd62}}, {4{16'hFFFF}});
        skin({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, 24'hFFFFFF, '0);
        skin(pick_vec(), pick_vec(), {6'd3, 6'd2, 6'd1, 6'd0}, {4{16'h8000}});
        skin(pick_vec(), pick_vec(), {6'd0, 6'd63, 6'd0, 6'd63}, 64'hFFFF_0000_FFFF_0000);
        skin({3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, 24'h555555, 64'h0001_0001_0001_0001);
        // Saturating joint: all-maximum matrix.
        for (int e = 0; e < 16; e++) load_word(10'(61 * 16 + e), 32'h7FFF_FFFF);
        skin({3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, {4{6'd61}}, {4{16'hFFFF}});
        skin({3{32'h8000_0000}}, {3{32'h8000_0000}}, {4{6'd61}}, {4{16'h8000}});
        // Reload and use immediately: a load just before a vertex.
        load_word(10'(61 * 16), 32'h8000_0000);
        skin({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {4{6'd61}}, {4{16'hFFFF}});
        fill_joint(61, 0);
        // Unused elements 12 and 15 written with extremes.
        load_word(10'(5 * 16 + 12), 32'h8000_0000);
        load_word(10'(5 * 16 + 15), 32'h7FFF_FFFF);
        skin(pick_vec(), pick_vec(), {4{6'd5}}, pick_weights());

        // Random traffic: mostly vertices, some palette rewrites.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) begin
                // Pause the sender until every outstanding vertex has drained.
                s_tvalid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            if ($urandom_range(0, 9) < 2) begin
                if ($urandom_range(0, 4) == 0) fill_joint($urandom_range(0, 63), 1);
                else load_word(10'($urandom), pick_word());
            end else begin
                skin(pick_vec(), pick_vec(), 24'($urandom), pick_weights());
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency to settle.
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_linear_blend_vertex_skinning OK");
        end else begin
            $display("tb_linear_blend_vertex_skinning NOT OK");
        end
        $finish;
    end
endmodule

### linear_blend_vertex_skinning.f
design/lbvs_pkg.sv
design/linear_blend_vertex_skinning.sv
tb/sv/lbvs_skin_checker.sv
tb/sv/tb_linear_blend_vertex_skinning.sv
